[rtl/core/xoro_pkg.sv]
// ----------------------------------------------------------------------------
// xoro_pkg
// Shared types and constants for the xoroshiro128+ generator unit.
// ----------------------------------------------------------------------------
`default_nettype none

package xoro_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned HALF_W = WORD_W / 2;

	localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [WORD_W-1:0] MIX_MUL_ONE  = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [WORD_W-1:0] MIX_MUL_TWO  = 64'h94d0_49bb_1331_11eb;
	localparam logic [WORD_W-1:0] NONZERO_FILL = 64'h8a5c_d789_635d_2dff;

	localparam int unsigned ROT_A     = 55;
	localparam int unsigned SHIFT_B   = 14;
	localparam int unsigned ROT_C     = 36;
	localparam int unsigned MIX_SH_1  = 30;
	localparam int unsigned MIX_SH_2  = 27;
	localparam int unsigned MIX_SH_3  = 31;

	localparam logic FUNC_DRAW = 1'b0;
	localparam logic FUNC_SEED = 1'b1;

	typedef enum logic [1:0] {
		MUL_LL,
		MUL_LH,
		MUL_HL
	} mul_step_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INC,
		ST_M1_LL,
		ST_M1_LH,
		ST_M1_HL,
		ST_MIX,
		ST_M2_LL,
		ST_M2_LH,
		ST_M2_HL,
		ST_APPLY,
		ST_FIX
	} xoro_state_t;

	typedef struct packed {
		logic      draw;
		logic      load_seed;
		logic      inc;
		logic      mul_en;
		mul_step_t mul_step;
		logic      mul_k2;
		logic      mix;
		logic      apply;
		logic      apply_b;
		logic      fix;
	} xoro_cmd_t;

	typedef struct packed {
		logic out_full;
	} xoro_status_t;

endpackage

`default_nettype wire

[rtl/core/xoro_ctrl.sv]
// ----------------------------------------------------------------------------
// xoro_ctrl
// Handshake control and seed sequencer for the xoroshiro128+ generator.
// ----------------------------------------------------------------------------
`default_nettype none

module xoro_ctrl import xoro_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic         func,
	input  wire logic         out_stall,
	input  wire xoro_status_t status,
	output xoro_cmd_t         cmd
);

	xoro_state_t state_q, state_d;
	logic        round_q, round_d;
	logic        accept;

	assign in_stall = (state_q != ST_IDLE) || (status.out_full && out_stall);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= 1'b0;
		end else begin
			state_q <= state_d;
			round_q <= round_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		round_d = round_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && func == FUNC_SEED) begin
					state_d = ST_INC;
					round_d = 1'b0;
				end
			end
			ST_INC:   state_d = ST_M1_LL;
			ST_M1_LL: state_d = ST_M1_LH;
			ST_M1_LH: state_d = ST_M1_HL;
			ST_M1_HL: state_d = ST_MIX;
			ST_MIX:   state_d = ST_M2_LL;
			ST_M2_LL: state_d = ST_M2_LH;
			ST_M2_LH: state_d = ST_M2_HL;
			ST_M2_HL: state_d = ST_APPLY;
			ST_APPLY: begin
				if (!round_q) begin
					state_d = ST_INC;
					round_d = 1'b1;
				end else begin
					state_d = ST_FIX;
				end
			end
			ST_FIX:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Datapath commands.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.draw      = accept && (func == FUNC_DRAW);
				cmd.load_seed = accept && (func == FUNC_SEED);
			end
			ST_INC: cmd.inc = 1'b1;
			ST_M1_LL: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = MUL_LL;
			end
			ST_M1_LH: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = MUL_LH;
			end
			ST_M1_HL: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = MUL_HL;
			end
			ST_MIX: cmd.mix = 1'b1;
			ST_M2_LL: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_k2   = 1'b1;
				cmd.mul_step = MUL_LL;
			end
			ST_M2_LH: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_k2   = 1'b1;
				cmd.mul_step = MUL_LH;
			end
			ST_M2_HL: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_k2   = 1'b1;
				cmd.mul_step = MUL_HL;
			end
			ST_APPLY: begin
				cmd.apply   = 1'b1;
				cmd.apply_b = round_q;
			end
			ST_FIX: cmd.fix = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/xoro_datapath.sv]
// ----------------------------------------------------------------------------
// xoro_datapath
// State halves, splitmix64 mixer with a shared 32x32 multiplier, and the
// output register of the xoroshiro128+ generator.
// ----------------------------------------------------------------------------
`default_nettype none

module xoro_datapath import xoro_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire xoro_cmd_t         cmd,
	output xoro_status_t           status,
	input  wire logic [WORD_W-1:0] seed_low_word,
	input  wire logic [WORD_W-1:0] seed_high_word,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [WORD_W-1:0]      random_word
);

	logic [WORD_W-1:0]   half_a_q, half_b_q;
	logic [WORD_W-1:0]   ctr_q, mop_q, acc_q;
	logic [WORD_W-1:0]   word_q;
	logic                valid_q;

	logic [WORD_W-1:0]   mixed, next_a, next_b;
	logic [WORD_W-1:0]   ctr_inc, finish;
	logic [WORD_W-1:0]   mul_k;
	logic [HALF_W-1:0]   op_x, op_y;
	logic [WORD_W-1:0]   prod;

	// xoroshiro128+ advance.
	assign mixed  = half_b_q ^ half_a_q;
	assign next_a = ((half_a_q << ROT_A) | (half_a_q >> (WORD_W - ROT_A)))
	              ^ mixed ^ (mixed << SHIFT_B);
	assign next_b = (mixed << ROT_C) | (mixed >> (WORD_W - ROT_C));

	assign ctr_inc = ctr_q + GOLDEN_GAMMA;
	assign finish  = acc_q ^ (acc_q >> MIX_SH_3);

	// Low 64 bits of the product, built from three 32x32 partial products.
	assign mul_k = cmd.mul_k2 ? MIX_MUL_TWO : MIX_MUL_ONE;
	assign op_x  = (cmd.mul_step == MUL_HL) ? mop_q[WORD_W-1:HALF_W] : mop_q[HALF_W-1:0];
	assign op_y  = (cmd.mul_step == MUL_LH) ? mul_k[WORD_W-1:HALF_W] : mul_k[HALF_W-1:0];
	assign prod  = WORD_W'(op_x) * WORD_W'(op_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_a_q <= '0;
			half_b_q <= '0;
			valid_q  <= 1'b0;
		end else begin
			if (cmd.draw) begin
				half_a_q <= next_a;
				half_b_q <= next_b;
			end else if (cmd.apply) begin
				if (cmd.apply_b) begin
					half_b_q <= half_b_q ^ finish;
				end else begin
					half_a_q <= half_a_q ^ finish;
				end
			end else if (cmd.fix) begin
				if ((half_a_q | half_b_q) == '0) begin
					half_a_q <= NONZERO_FILL;
				end
			end

			if (cmd.draw) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.draw) begin
			word_q <= half_a_q + half_b_q;
		end
		if (cmd.load_seed) begin
			ctr_q <= seed_low_word ^ (seed_high_word + GOLDEN_GAMMA);
		end else if (cmd.inc) begin
			ctr_q <= ctr_inc;
		end
		if (cmd.inc) begin
			mop_q <= ctr_inc ^ (ctr_inc >> MIX_SH_1);
		end else if (cmd.mix) begin
			mop_q <= acc_q ^ (acc_q >> MIX_SH_2);
		end
		if (cmd.mul_en) begin
			case (cmd.mul_step)
				MUL_LL:  acc_q <= prod;
				default: acc_q <= acc_q + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
			endcase
		end
	end

	assign status.out_full = valid_q;
	assign out_valid       = valid_q;
	assign random_word     = word_q;

endmodule

`default_nettype wire

[rtl/core/xoroshiro128plus_generator_unit.sv]
// ----------------------------------------------------------------------------
// xoroshiro128plus_generator_unit
// A draw transaction shows its result in the output register in the cycle
// after acceptance. Draws are taken one per cycle unless a waiting result is
// stalled; a seed transaction occupies the unit for one load, two splitmix64
// rounds on a shared 32x32 multiplier and one zero-state check.
// Reset: arst_n clears both state halves and the control state at once.
// ----------------------------------------------------------------------------
`default_nettype none

// The unit keeps a 128-bit xoroshiro128+ state. A draw transaction (func 0)
// returns the sum of the two state halves and advances the state with
// rotations 55 and 36 and shift 14; that work is a few adds, XORs and rotates,
// so unstalled draws stream at one per cycle. A seed transaction (func 1)
// folds its two words into a counter and XORs two splitmix64 outputs of that
// counter into the state halves. Each splitmix64 round needs two 64-bit
// multiplies, which run as three partial products each on one shared
// 32x32 multiplier under control of the sequencer. A seed transaction gives
// no result. If seeding leaves the state all zero, half a is loaded with a
// fixed non-zero constant.
//
// The result sits in an output register, so a new draw is accepted while an
// earlier result is still waiting as long as that result is taken in the
// same cycle.
module xoroshiro128plus_generator_unit import xoro_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              func,
	input  wire logic [WORD_W-1:0] seed_low_word,
	input  wire logic [WORD_W-1:0] seed_high_word,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [WORD_W-1:0]      random_word
);

	xoro_cmd_t    cmd;
	xoro_status_t status;

	// The controller owns the handshake and the seed sequence.
	xoro_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the state, the mixer and the output register.
	xoro_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.seed_low_word  (seed_low_word),
		.seed_high_word (seed_high_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.random_word    (random_word)
	);

endmodule

`default_nettype wire
